>>> rtl/arp_pkg.sv
// Shared types and constants for the audio resample packetizer.
// Used by every module of the block; no dependencies.
`default_nettype none

package arp_pkg;

  localparam int unsigned PACKET_FRAMES = 960;
  localparam int unsigned OUTPUT_RATE   = 48000;
  localparam int unsigned MIN_RATE      = 8000;
  localparam int unsigned MAX_RESULTS   = 6;

  localparam int unsigned RATE_W  = 19;
  localparam int unsigned PHASE_W = 20;
  localparam int unsigned FRAME_W = 10;
  localparam int unsigned CFG_W   = 19;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [14:0] FLT_SCALE = 15'd32767;

  localparam logic [CIDX_W-1:0] REG_SOURCE_RATE   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SAMPLE_FORMAT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_STEREO_SOURCE = 2'd2;

  localparam logic [1:0] FMT_FLOAT = 2'd0;
  localparam logic [1:0] FMT_PCM16 = 2'd1;
  localparam logic [1:0] FMT_PCM32 = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;

  typedef struct packed {
    logic [31:0] first_channel_raw;
    logic [31:0] second_channel_raw;
    logic        buffer_start;
    logic        silent;
    logic [63:0] time_ns;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [15:0]        packet_sequence;
    logic               first_of_packet;
    logic               last_of_packet;
    logic [63:0]        packet_time_ns;
    logic               last_of_run;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic rnd;
    logic fin;
    logic chan;
    logic step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic below;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/arp_conv.sv
// Shared sample converter: float32 multiply, single-precision round,
// final shift and round, plus pcm pass-through. Depends on arp_pkg.
`default_nettype none

module arp_conv (
  input  wire logic               clk_i,
  input  wire arp_pkg::cmd_t      cmd_i,
  input  wire logic [31:0]        raw_i,
  input  wire logic [1:0]         fmt_i,
  input  wire logic               silent_i,
  output logic signed [15:0]      sample_o
);

  logic [31:0] raw_q;
  logic [38:0] prod_q;
  logic [24:0] q_q, q_d;
  logic        sh_q;

  logic [23:0] hi;
  logic        g1, s1, up1;

  logic [7:0]  ex;
  logic [7:0]  t, s;
  logic [5:0]  sa, sm1;
  logic [24:0] shifted, lowmask;
  logic        g2, s2;
  logic [16:0] mag;
  logic [15:0] magx, fval, conv;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      raw_q  <= raw_i;
      prod_q <= 39'({1'b1, raw_i[22:0]}) * 39'(arp_pkg::FLT_SCALE);
    end
    if (cmd_i.rnd) begin
      q_q  <= q_d;
      sh_q <= prod_q[38];
    end
  end

  // round product to 24 significant bits, nearest even
  always_comb begin
    if (prod_q[38]) begin
      hi = prod_q[38:15];
      g1 = prod_q[14];
      s1 = |prod_q[13:0];
    end else begin
      hi = prod_q[37:14];
      g1 = prod_q[13];
      s1 = |prod_q[12:0];
    end
    up1 = g1 && (s1 || hi[0]);
    q_d = {1'b0, hi} + 25'(up1);
  end

  always_comb begin
    ex      = raw_q[30:23];
    t       = 8'd150 - ex;
    s       = t - (sh_q ? 8'd15 : 8'd14);
    sa      = s[5:0];
    sm1     = sa - 6'd1;
    shifted = q_q >> sa;
    g2      = |((q_q >> sm1) & 25'd1);
    lowmask = (25'd1 << sm1) - 25'd1;
    s2      = |(q_q & lowmask);
    mag     = shifted[16:0] + 17'(g2 && (s2 || shifted[0]));
    magx    = (mag > 17'd32767) ? 16'h7FFF : {1'b0, mag[14:0]};

    if (ex == 8'hFF && raw_q[22:0] != 23'd0) begin
      fval = 16'h7FFF;
    end else if (ex >= 8'd127) begin
      fval = raw_q[31] ? 16'h8001 : 16'h7FFF;
    end else if (ex < 8'd100) begin
      fval = 16'h0000;
    end else begin
      fval = raw_q[31] ? (~magx + 16'd1) : magx;
    end

    case (fmt_i)
      arp_pkg::FMT_FLOAT: conv = fval;
      arp_pkg::FMT_PCM16: conv = raw_q[15:0];
      default:            conv = raw_q[31:16];
    endcase
  end

  assign sample_o = silent_i ? 16'sd0 : $signed(conv);

endmodule

`default_nettype wire

>>> rtl/arp_ctrl.sv
// Sequencing state machine: accept, two conversion passes, resample loop.
// Depends on arp_pkg for the command and status structs.
`default_nettype none

module arp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire arp_pkg::status_t status_i,
  output arp_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL0, S_RND0, S_FIN0, S_MUL1, S_RND1, S_FIN1, S_LOOP
  } state_e;

  state_e state_q, state_d;
  logic   in_ready_q;
  logic   accept;

  assign accept     = in_valid_i && in_ready_q;
  assign in_ready_o = in_ready_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_MUL0;
      S_MUL0: state_d = S_RND0;
      S_RND0: state_d = S_FIN0;
      S_FIN0: state_d = S_MUL1;
      S_MUL1: state_d = S_RND1;
      S_RND1: state_d = S_FIN1;
      S_FIN1: state_d = S_LOOP;
      S_LOOP: if (!status_i.below) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.load = accept;
    unique case (state_q)
      S_MUL0: cmd_o.mul = 1'b1;
      S_RND0: cmd_o.rnd = 1'b1;
      S_FIN0: cmd_o.fin = 1'b1;
      S_MUL1: begin
        cmd_o.mul  = 1'b1;
        cmd_o.chan = 1'b1;
      end
      S_RND1: begin
        cmd_o.rnd  = 1'b1;
        cmd_o.chan = 1'b1;
      end
      S_FIN1: begin
        cmd_o.fin  = 1'b1;
        cmd_o.chan = 1'b1;
      end
      S_LOOP: cmd_o.step = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      state_q    <= state_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

endmodule

`default_nettype wire

>>> rtl/arp_datapath.sv
// Datapath: config registers, word register, converter, phase residue,
// packet counters and output register. Depends on arp_pkg and arp_conv.
`default_nettype none

module arp_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [arp_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [arp_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire arp_pkg::in_word_t           in_data_i,
  input  wire arp_pkg::cmd_t               cmd_i,
  output arp_pkg::status_t                 status_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output arp_pkg::out_word_t               out_data_o
);

  logic [arp_pkg::RATE_W-1:0]  src_rate_q;
  logic [1:0]                  fmt_q;
  logic                        stereo_q;

  arp_pkg::in_word_t           item_q;
  logic signed [15:0]          left_q, right_q, sample;
  logic [arp_pkg::RATE_W-1:0]  residue_q, rate;
  logic [arp_pkg::PHASE_W-1:0] p_q, p_next;
  logic [2:0]                  n_q;
  logic [arp_pkg::FRAME_W-1:0] fip_q;
  logic [15:0]                 seq_q;
  logic                        out_valid_q;
  arp_pkg::out_word_t          out_q, out_d;

  logic produce, emit_en, out_free, below, emit, advance, pkt_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q <= arp_pkg::RATE_W'(arp_pkg::OUTPUT_RATE);
      fmt_q      <= arp_pkg::FMT_FLOAT;
      stereo_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        arp_pkg::REG_SOURCE_RATE:   src_rate_q <= cfg_wdata_i[arp_pkg::RATE_W-1:0];
        arp_pkg::REG_SAMPLE_FORMAT: fmt_q      <= cfg_wdata_i[1:0];
        arp_pkg::REG_STEREO_SOURCE: stereo_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  arp_conv u_conv (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .raw_i    (cmd_i.chan ? item_q.second_channel_raw : item_q.first_channel_raw),
    .fmt_i    (fmt_q),
    .silent_i (item_q.silent),
    .sample_o (sample)
  );

  assign rate     = (src_rate_q < arp_pkg::RATE_W'(arp_pkg::MIN_RATE))
                  ? arp_pkg::RATE_W'(arp_pkg::MIN_RATE) : src_rate_q;
  assign p_next   = p_q + arp_pkg::PHASE_W'(rate);
  assign below    = p_q < arp_pkg::PHASE_W'(arp_pkg::OUTPUT_RATE);
  assign produce  = item_q.silent || (fmt_q != arp_pkg::FMT_NONE);
  assign emit_en  = produce && (n_q < 3'(arp_pkg::MAX_RESULTS));
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cmd_i.step && below && emit_en && out_free;
  assign advance  = cmd_i.step && below && (!emit_en || out_free);
  assign pkt_last = fip_q >= arp_pkg::FRAME_W'(arp_pkg::PACKET_FRAMES - 1);

  always_comb begin
    out_d.left_sample     = left_q;
    out_d.right_sample    = right_q;
    out_d.packet_sequence = seq_q;
    out_d.first_of_packet = (fip_q == '0);
    out_d.last_of_packet  = pkt_last;
    out_d.packet_time_ns  = pkt_last ? item_q.time_ns : 64'd0;
    out_d.last_of_run     = (p_next >= arp_pkg::PHASE_W'(arp_pkg::OUTPUT_RATE))
                         || (n_q == 3'(arp_pkg::MAX_RESULTS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.fin && !cmd_i.chan) left_q <= sample;
    if (cmd_i.fin && cmd_i.chan) right_q <= stereo_q ? sample : left_q;
    if (emit) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      residue_q   <= '0;
      p_q         <= '0;
      n_q         <= '0;
      fip_q       <= '0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        p_q <= in_data_i.buffer_start ? '0 : {1'b0, residue_q};
        n_q <= '0;
      end else if (advance) begin
        p_q <= p_next;
      end
      if (cmd_i.step && !below) begin
        residue_q <= arp_pkg::RATE_W'(p_q - arp_pkg::PHASE_W'(arp_pkg::OUTPUT_RATE));
      end
      if (emit) begin
        n_q <= n_q + 3'd1;
        if (pkt_last) begin
          fip_q <= '0;
          seq_q <= seq_q + 16'd1;
        end else begin
          fip_q <= fip_q + arp_pkg::FRAME_W'(1);
        end
      end
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.below = below;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

`default_nettype wire

>>> rtl/audio_resample_packetizer_unit.sv
// Top level of the audio resample packetizer: controller plus datapath.
// Depends on arp_pkg, arp_ctrl, arp_datapath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_ready_o   arp_pkg::in_word_t
//   out      source     out_valid_o/out_ready_i arp_pkg::out_word_t
//   cfg      sink       cfg_we_i                cfg_index_i, cfg_wdata_i
//
// An input word passes through these steps from accept to next accept: taking it,
// the two conversion passes (multiply, round, final) through the shared float unit,
// the resample steps (zero to six, one frame each unless the format is unsupported
// and the word is not silent) and storing the phase residue.
// Reset is asynchronous; no clearing pass. A stalled output holds the
// resample loop; the next input word is taken while the last frame waits.
`default_nettype none

module audio_resample_packetizer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire arp_pkg::in_word_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output arp_pkg::out_word_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [arp_pkg::CIDX_W-1:0] cfg_index_i,
  input  wire logic [arp_pkg::CFG_W-1:0]  cfg_wdata_i
);

  arp_pkg::cmd_t    cmd;
  arp_pkg::status_t status;

  arp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  arp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/arp_checker.sv
// Port-level assertions for the audio resample packetizer, bound to the
// top level. Depends on arp_pkg and audio_resample_packetizer_unit.
`default_nettype none

module arp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire arp_pkg::out_word_t         out_data_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // the first conversion cycle never loads a new output word
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> $stable(out_data_o))
    else $error("output loaded during conversion");

  // more frames of this run still to come
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !in_ready_o)
    else $error("input ready before run finished");

endmodule

bind audio_resample_packetizer_unit arp_checker u_arp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> verif/arp_tb_pkg.sv
// Frame scoreboard for the audio resample packetizer testbench: predicts the
// output frames of each accepted input word and checks the frames that leave.
// Depends on arp_pkg.
`timescale 1ns / 100ps

package arp_tb_pkg;
  import arp_pkg::*;

  class frame_scoreboard;
    logic [RATE_W-1:0]  source_rate;
    logic [1:0]         sample_format;
    logic               stereo_source;
    logic [RATE_W-1:0]  phase_residue;
    logic [FRAME_W-1:0] frame_in_packet;
    logic [15:0]        sequence_count;
    out_word_t          expected_frames[$];
    int unsigned        mismatches;

    function new();
      source_rate     = RATE_W'(48000);
      sample_format   = FMT_FLOAT;
      stereo_source   = 1'b1;
      phase_residue   = '0;
      frame_in_packet = '0;
      sequence_count  = '0;
      mismatches      = 0;
    endfunction

    function void set_config(logic [RATE_W-1:0] rate, logic [1:0] fmt, logic stereo);
      source_rate   = rate;
      sample_format = fmt;
      stereo_source = stereo;
    endfunction

    function int unsigned pending();
      return expected_frames.size();
    endfunction

    task report(string what, logic [63:0] got_v, logic [63:0] exp_v);
      $display("mismatch %s: got %0h expected %0h", what, got_v, exp_v);
      mismatches++;
    endtask

    function logic [63:0] round_half_even(logic [63:0] v, int unsigned sh);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      if (sh == 0) return v;
      q    = v >> sh;
      rem  = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return q;
    endfunction

    function logic [15:0] float_to_pcm(logic [31:0] bits);
      logic [7:0]  ex;
      logic [22:0] man;
      logic [63:0] prod;
      logic [63:0] mag;
      int unsigned nb;
      int unsigned t;
      ex  = bits[30:23];
      man = bits[22:0];
      if (ex == 8'hFF && man != 0) return 16'h7FFF;
      if (ex >= 127) return bits[31] ? 16'h8001 : 16'h7FFF;
      if (ex < 100) return 16'h0000;
      prod = {40'd0, 1'b1, man} * 64'd32767;
      nb = 0;
      while (nb < 64 && (prod >> nb) != 0) nb++;
      // product back to single precision first
      if (nb > 24) prod = round_half_even(prod, nb - 24) << (nb - 24);
      t   = 150 - ex;
      mag = round_half_even(prod, t);
      if (mag > 64'd32767) mag = 64'd32767;
      return bits[31] ? -mag[15:0] : mag[15:0];
    endfunction

    function logic [15:0] convert(logic [31:0] raw);
      case (sample_format)
        FMT_FLOAT: return float_to_pcm(raw);
        FMT_PCM16: return raw[15:0];
        default:   return raw[31:16];
      endcase
    endfunction

    function void note_input(in_word_t w);
      logic [15:0] left;
      logic [15:0] right;
      logic [31:0] p;
      logic [31:0] rate;
      bit          produce;
      bit          last;
      int unsigned n;
      out_word_t   f;
      rate    = (source_rate < MIN_RATE) ? 32'(MIN_RATE) : 32'(source_rate);
      produce = w.silent || sample_format != FMT_NONE;
      left    = '0;
      right   = '0;
      if (produce && !w.silent) begin
        left  = convert(w.first_channel_raw);
        right = stereo_source ? convert(w.second_channel_raw) : left;
      end
      p = w.buffer_start ? 32'd0 : 32'(phase_residue);
      n = 0;
      while (p < OUTPUT_RATE) begin
        if (produce && n < MAX_RESULTS) begin
          last              = frame_in_packet >= PACKET_FRAMES - 1;
          f.left_sample     = left;
          f.right_sample    = right;
          f.packet_sequence = sequence_count;
          f.first_of_packet = frame_in_packet == 0;
          f.last_of_packet  = last;
          f.packet_time_ns  = last ? w.time_ns : 64'd0;
          f.last_of_run     = 1'b0;
          expected_frames.insert(expected_frames.size(), f);
          if (last) begin
            frame_in_packet = '0;
            sequence_count  = sequence_count + 16'd1;
          end else begin
            frame_in_packet = frame_in_packet + 1'b1;
          end
          n++;
        end
        p += rate;
      end
      phase_residue = RATE_W'(p - OUTPUT_RATE);
      if (n > 0) expected_frames[expected_frames.size() - 1].last_of_run = 1'b1;
    endfunction

    task check_output(out_word_t got);
      out_word_t e;
      if (expected_frames.size() == 0) begin
        report("frame with none outstanding", 64'(got.packet_sequence), 64'd0);
        return;
      end
      e = expected_frames.pop_front();
      if (got.left_sample !== e.left_sample)
        report("left_sample", 64'(got.left_sample), 64'(e.left_sample));
      if (got.right_sample !== e.right_sample)
        report("right_sample", 64'(got.right_sample), 64'(e.right_sample));
      if (got.packet_sequence !== e.packet_sequence)
        report("packet_sequence", 64'(got.packet_sequence), 64'(e.packet_sequence));
      if (got.first_of_packet !== e.first_of_packet)
        report("first_of_packet", 64'(got.first_of_packet), 64'(e.first_of_packet));
      if (got.last_of_packet !== e.last_of_packet)
        report("last_of_packet", 64'(got.last_of_packet), 64'(e.last_of_packet));
      if (got.packet_time_ns !== e.packet_time_ns)
        report("packet_time_ns", got.packet_time_ns, e.packet_time_ns);
      if (got.last_of_run !== e.last_of_run)
        report("last_of_run", 64'(got.last_of_run), 64'(e.last_of_run));
    endtask

    task finish_check();
      if (expected_frames.size() != 0)
        report("frames outstanding at end", 64'(expected_frames.size()), 64'd0);
    endtask
  endclass

endpackage

>>> verif/tb_top.sv
// Top of the audio resample packetizer testbench: clock, reset, word drivers,
// configuration phases and result sink. Depends on arp_pkg, arp_tb_pkg and
// audio_resample_packetizer_unit.
`timescale 1ns / 100ps

module tb_top;
  import arp_pkg::*;
  import arp_tb_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_AFTER    = 100;
  localparam int unsigned EDGE_COUNT    = 13;

  localparam logic [31:0] FLOAT_EDGES [EDGE_COUNT] = '{
    32'h3F800000, 32'hBF800000, 32'h7F800000, 32'hFF800000, 32'h7FC00000,
    32'hFF800001, 32'h00000000, 32'h80000000, 32'h3F7FFFFF, 32'h33FFFFFF,
    32'h32000000, 32'h31FFFFFF, 32'h3F000000
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_word_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_word_t           out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CIDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]    cfg_wdata_i = '0;

  bit                  idle_en     = 1'b1;
  int unsigned         cycle_count = 0;
  frame_scoreboard     sb          = new();

  audio_resample_packetizer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic in_word_t make_word(logic [31:0] first, logic [31:0] second,
                                         logic start, logic quiet, logic [63:0] stamp);
    in_word_t w;
    w.first_channel_raw  = first;
    w.second_channel_raw = second;
    w.buffer_start       = start;
    w.silent             = quiet;
    w.time_ns            = stamp;
    return w;
  endfunction

  function automatic logic [31:0] random_sample(logic [1:0] fmt);
    logic [31:0] v;
    int unsigned pick;
    v    = $urandom;
    pick = $urandom_range(0, 99);
    if (fmt == FMT_FLOAT) begin
      if (pick < 60) v[30:23] = 8'($urandom_range(96, 127));
      else if (pick < 75) v = FLOAT_EDGES[$urandom_range(0, EDGE_COUNT - 1)];
    end
    return v;
  endfunction

  function automatic logic [63:0] random_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = 0;
    while (idle_en && $urandom_range(0, 99) < 10) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(w);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
  endtask

  task automatic configure(input logic [RATE_W-1:0] rate, input logic [1:0] fmt,
                           input logic stereo);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SOURCE_RATE;
    cfg_wdata_i <= CFG_W'(rate);
    @(posedge clk_i);
    cfg_index_i <= REG_SAMPLE_FORMAT;
    cfg_wdata_i <= CFG_W'(fmt);
    @(posedge clk_i);
    cfg_index_i <= REG_STEREO_SOURCE;
    cfg_wdata_i <= CFG_W'(stereo);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(rate, fmt, stereo);
  endtask

  task automatic run_random(input int unsigned count, input logic [1:0] fmt);
    in_word_t w;
    for (int unsigned i = 0; i < count; i++) begin
      w = make_word(random_sample(fmt), random_sample(fmt),
                    $urandom_range(0, 9) == 0, $urandom_range(0, 11) == 0,
                    random_stamp());
      send_word(w);
    end
    stop_sending();
  endtask

  initial begin : sink
    int unsigned hold_left;
    int unsigned seen;
    bit          held_once;
    hold_left = 0;
    seen      = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_output(out_data_o);
        seen++;
      end
      // one long hold-off so the block backs up into its input
      if (!held_once && seen == HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_en && $urandom_range(0, 99) < 10);
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // float edges, six frames per word
    configure(RATE_W'(8000), FMT_FLOAT, 1'b1);
    send_word(make_word(32'h3F800000, 32'hBF800000, 1'b1, 1'b0, 64'd0));
    send_word(make_word(32'h7F800000, 32'hFF800000, 1'b0, 1'b0, '1));
    send_word(make_word(32'h7FC00000, 32'hFF800001, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h3F000000, 32'hBF000000, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h3F7FFFFF, 32'h32000000, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h31FFFFFF, 32'h00000001, 1'b1, 1'b0, random_stamp()));
    send_word(make_word(32'h00000000, 32'h80000000, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h3F800000, 32'hBF800000, 1'b0, 1'b1, random_stamp()));
    stop_sending();

    // mono pcm16, rate below the floor
    configure('0, FMT_PCM16, 1'b0);
    send_word(make_word(32'hFFFF7FFF, 32'h12345678, 1'b1, 1'b0, random_stamp()));
    send_word(make_word(32'h00008000, 32'hFFFFFFFF, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h12340000, 32'h00000000, 1'b0, 1'b0, random_stamp()));
    stop_sending();

    // pcm32 at the top rate: words without buffer_start give no frame
    configure('1, FMT_PCM32, 1'b1);
    send_word(make_word(32'h7FFF0000, 32'h8000FFFF, 1'b1, 1'b0, random_stamp()));
    send_word(make_word(32'hFFFFFFFF, 32'h0000FFFF, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h00010000, 32'hFFFE0000, 1'b1, 1'b0, random_stamp()));
    stop_sending();

    // unsupported format: non-silent words give no frame
    configure(RATE_W'(48000), FMT_NONE, 1'b1);
    send_word(make_word(32'h3F800000, 32'h3F800000, 1'b0, 1'b0, random_stamp()));
    send_word(make_word(32'h3F800000, 32'h3F800000, 1'b0, 1'b1, random_stamp()));
    send_word(make_word(32'h12345678, 32'h9ABCDEF0, 1'b1, 1'b0, random_stamp()));
    stop_sending();

    configure(RATE_W'(8000), FMT_FLOAT, 1'b1);
    run_random(55, FMT_FLOAT);

    idle_en = 1'b0;
    configure('0, FMT_PCM16, 1'b0);
    run_random(40, FMT_PCM16);
    idle_en = 1'b1;

    configure(RATE_W'(44100), FMT_PCM32, 1'b1);
    run_random(20, FMT_PCM32);

    configure(RATE_W'(384000), FMT_FLOAT, 1'b0);
    run_random(15, FMT_FLOAT);

    configure('1, FMT_NONE, 1'b1);
    run_random(15, FMT_NONE);

    configure(RATE_W'(11025), FMT_FLOAT, 1'b1);
    run_random(20, FMT_FLOAT);

    configure(RATE_W'(7999), FMT_PCM16, 1'b1);
    run_random(20, FMT_PCM16);

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/arp_pkg.sv
rtl/arp_conv.sv
rtl/arp_ctrl.sv
rtl/arp_datapath.sv
rtl/audio_resample_packetizer_unit.sv
rtl/arp_checker.sv
verif/arp_tb_pkg.sv
verif/tb_top.sv
